[rtl/psr_pkg.sv]
package psr_pkg;

    // Field widths
    localparam int POS_W    = 14;
    localparam int SPEED_W  = 16;
    localparam int FUNC_W   = 2;
    localparam int BRIGHT_W = 8;
    localparam int SECS_W   = 16;

    // The step is at most 65535/10, so it fits in 13 bits
    localparam int STEP_W   = 13;

    // Remaining-time dividend: distance*100, at most 1000000
    localparam int MS_W     = 20;
    localparam int DIV_ITER = MS_W;
    localparam int CNT_W    = $clog2(DIV_ITER + 1);

    localparam logic [POS_W-1:0] POS_MAX = POS_W'(10000);

    // Request codes
    localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_START = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_STOP  = 2'd2;

    // Result kinds
    localparam logic EVT_UPDATE  = 1'b0;
    localparam logic EVT_STOPPED = 1'b1;

    // Scale of distance per tick (100 ms)
    localparam logic [6:0] TICK_SCALE = 7'd100;

    // floor(x/10) for any 16-bit x: (x*52429) >> 19
    localparam int                STEP_RECIP_W = 17;
    localparam logic [16:0]       STEP_RECIP   = 17'd52429;
    localparam int                STEP_SHIFT   = 19;

    // floor(x/1000) for x below 2^20: (x*1073742) >> 30
    localparam int                SEC_RECIP_W  = 21;
    localparam logic [20:0]       SEC_RECIP    = 21'd1073742;
    localparam int                SEC_SHIFT    = 30;
    localparam logic [MS_W:0]     SEC_BIAS     = 21'd999;
    localparam logic [SECS_W-1:0] SECS_NO_STEP = 16'hFFFF;

    // floor(y/10000) for y below 2^22: (y*1717987) >> 34
    localparam int                BRI_Y_W      = 22;
    localparam int                BRI_RECIP_W  = 21;
    localparam logic [20:0]       BRI_RECIP    = 21'd1717987;
    localparam int                BRI_SHIFT    = 34;
    localparam logic [7:0]        BRI_SCALE    = 8'd255;
    localparam logic [BRI_Y_W-1:0] BRI_BIAS    = 22'd5000;

    typedef struct packed {
        logic              start;
        logic [MS_W-1:0]   num;
        logic [STEP_W-1:0] den;
    } psr_div_req_t;

    typedef struct packed {
        logic            done;
        logic [MS_W-1:0] quotient;
    } psr_div_rsp_t;

endpackage

[rtl/psr_div.sv]
module psr_div (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  psr_pkg::psr_div_req_t req,
    output psr_pkg::psr_div_rsp_t rsp
);

    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;
    logic [psr_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    logic [psr_pkg::STEP_W-1:0]   rem_reg, rem_next;
    logic [psr_pkg::STEP_W-1:0]   den_reg, den_next;
    logic [psr_pkg::MS_W-1:0]     quo_reg, quo_next;

    logic [psr_pkg::STEP_W:0]     shifted;
    logic [psr_pkg::STEP_W:0]     diff;
    logic                         fits;

    // One restoring step per cycle: shift in the next dividend bit, subtract if it fits
    assign shifted = {rem_reg, quo_reg[psr_pkg::MS_W-1]};
    assign diff    = shifted - {1'b0, den_reg};
    assign fits    = shifted >= {1'b0, den_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = psr_pkg::CNT_W'(psr_pkg::DIV_ITER);
            rem_next  = '0;
            den_next  = req.den;
            quo_next  = req.num;
        end else if (busy_reg) begin
            rem_next = fits ? diff[psr_pkg::STEP_W-1:0] : shifted[psr_pkg::STEP_W-1:0];
            quo_next = {quo_reg[psr_pkg::MS_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == psr_pkg::CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

[rtl/position_slew_ramp_core.sv]
// Slew-rate limited position ramp.
// Input channel (s_valid/s_ready): one request per accepted item. A start request
// loads the target (saturated to 10000) and the speed and begins moving; a tick
// request advances the position by speed/10 toward the target; a stop request
// halts and reports the position. Selector three is dropped.
// Result channel (m_valid/m_ready): one result per stop request and per tick while
// moving: either an update (position, brightness, seconds left, just-started flag)
// or a stopped report on arrival. Start and idle ticks produce no result.
// A tick that leaves the position short of the target passes through the step,
// divide, seconds and emit states; the restoring divider forms distance*100/step.
// Arrival and zero step go from the step state to emit; a stop goes from idle to emit.
// s_ready is high only while the sequencer is idle; the sequencer returns to idle
// on the same edge that registers the result.
// A stalled receiver holds the result in the output register; the block still
// accepts further requests until one yields a result, and holds that result at the
// final state until the output register frees up.
// Reset (aresetn low, synchronous) clears the position, target, step and the
// moving flag, and drops any pending result.
module position_slew_ramp_core (
    input  logic                           aclk,
    input  logic                           aresetn,

    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [psr_pkg::FUNC_W-1:0]     s_func,
    input  logic [psr_pkg::POS_W-1:0]      s_target_position,
    input  logic [psr_pkg::SPEED_W-1:0]    s_move_speed,

    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_event_kind,
    output logic [psr_pkg::POS_W-1:0]      m_position,
    output logic [psr_pkg::BRIGHT_W-1:0]   m_brightness,
    output logic [psr_pkg::SECS_W-1:0]     m_time_left_s,
    output logic                           m_just_started
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_STEP = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_SECS = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;

    localparam int STEP_PROD_W = psr_pkg::SPEED_W + psr_pkg::STEP_RECIP_W;
    localparam int SEC_PROD_W  = psr_pkg::MS_W + 1 + psr_pkg::SEC_RECIP_W;
    localparam int BRI_PROD_W  = psr_pkg::BRI_Y_W + psr_pkg::BRI_RECIP_W;
    localparam int NUM_W       = psr_pkg::POS_W + 7;

    logic [2:0]                    state_reg, state_next;
    logic [psr_pkg::POS_W-1:0]     cur_pos_reg, cur_pos_next;
    logic [psr_pkg::POS_W-1:0]     tgt_pos_reg, tgt_pos_next;
    logic [psr_pkg::STEP_W-1:0]    step_reg, step_next;
    logic                          moving_reg, moving_next;
    logic                          first_reg, first_next;
    logic                          kind_reg, kind_next;
    logic [psr_pkg::SECS_W-1:0]    secs_reg, secs_next;
    logic                          just_reg, just_next;

    logic                          m_valid_reg, m_valid_next;
    logic                          m_kind_reg, m_kind_next;
    logic [psr_pkg::POS_W-1:0]     m_pos_reg, m_pos_next;
    logic [psr_pkg::BRIGHT_W-1:0]  m_bright_reg, m_bright_next;
    logic [psr_pkg::SECS_W-1:0]    m_secs_reg, m_secs_next;
    logic                          m_just_reg, m_just_next;

    logic                          s_accept;
    logic                          out_free;

    logic [psr_pkg::POS_W-1:0]     tgt_sat;
    logic [STEP_PROD_W-1:0]        step_prod;

    logic                          going_up;
    logic [psr_pkg::POS_W-1:0]     dist_abs;
    logic                          arrive;
    logic [NUM_W-1:0]              num_full;

    logic [psr_pkg::MS_W:0]        ms_biased;
    logic [SEC_PROD_W-1:0]         sec_prod;

    logic [psr_pkg::BRI_Y_W-1:0]   bri_y;
    logic [BRI_PROD_W-1:0]         bri_prod;

    psr_pkg::psr_div_req_t         div_req;
    psr_pkg::psr_div_rsp_t         div_rsp;

    psr_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign s_ready  = state_reg == ST_IDLE;
    assign s_accept = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // Start: saturate the target, and form step = speed/10 by reciprocal multiply
    assign tgt_sat   = (s_target_position > psr_pkg::POS_MAX) ? psr_pkg::POS_MAX
                                                              : s_target_position;
    assign step_prod = STEP_PROD_W'(s_move_speed) * STEP_PROD_W'(psr_pkg::STEP_RECIP);

    // Tick: distance before this step, and whether this step reaches the target
    assign going_up = cur_pos_reg <= tgt_pos_reg;
    assign dist_abs = going_up ? (tgt_pos_reg - cur_pos_reg) : (cur_pos_reg - tgt_pos_reg);
    assign arrive   = {1'b0, step_reg} >= dist_abs;
    assign num_full = NUM_W'(dist_abs) * NUM_W'(psr_pkg::TICK_SCALE);

    // Seconds left: ceil(ms/1000) as floor((ms+999)/1000)
    assign ms_biased = {1'b0, div_rsp.quotient} + psr_pkg::SEC_BIAS;
    assign sec_prod  = SEC_PROD_W'(ms_biased) * SEC_PROD_W'(psr_pkg::SEC_RECIP);

    // Brightness: round(pos*255/10000)
    assign bri_y    = psr_pkg::BRI_Y_W'(cur_pos_reg) * psr_pkg::BRI_Y_W'(psr_pkg::BRI_SCALE)
                    + psr_pkg::BRI_BIAS;
    assign bri_prod = BRI_PROD_W'(bri_y) * BRI_PROD_W'(psr_pkg::BRI_RECIP);

    always_comb begin
        state_next    = state_reg;
        cur_pos_next  = cur_pos_reg;
        tgt_pos_next  = tgt_pos_reg;
        step_next     = step_reg;
        moving_next   = moving_reg;
        first_next    = first_reg;
        kind_next     = kind_reg;
        secs_next     = secs_reg;
        just_next     = just_reg;

        m_valid_next  = m_valid_reg;
        m_kind_next   = m_kind_reg;
        m_pos_next    = m_pos_reg;
        m_bright_next = m_bright_reg;
        m_secs_next   = m_secs_reg;
        m_just_next   = m_just_reg;

        div_req.start = 1'b0;
        div_req.num   = psr_pkg::MS_W'(num_full);
        div_req.den   = step_reg;

        // Drop the result once the receiver takes it
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    case (s_func)
                        psr_pkg::FUNC_START: begin
                            tgt_pos_next = tgt_sat;
                            step_next    = step_prod[psr_pkg::STEP_SHIFT +: psr_pkg::STEP_W];
                            moving_next  = 1'b1;
                            first_next   = 1'b1;
                        end
                        psr_pkg::FUNC_STOP: begin
                            moving_next = 1'b0;
                            kind_next   = psr_pkg::EVT_STOPPED;
                            secs_next   = '0;
                            just_next   = 1'b0;
                            state_next  = ST_EMIT;
                        end
                        psr_pkg::FUNC_TICK: begin
                            if (moving_reg) begin
                                state_next = ST_STEP;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_STEP: begin
                if (arrive) begin
                    // Snap to the target and report arrival
                    cur_pos_next = tgt_pos_reg;
                    moving_next  = 1'b0;
                    kind_next    = psr_pkg::EVT_STOPPED;
                    secs_next    = '0;
                    just_next    = 1'b0;
                    state_next   = ST_EMIT;
                end else begin
                    cur_pos_next = going_up ? (cur_pos_reg + psr_pkg::POS_W'(step_reg))
                                            : (cur_pos_reg - psr_pkg::POS_W'(step_reg));
                    kind_next    = psr_pkg::EVT_UPDATE;
                    just_next    = first_reg;
                    first_next   = 1'b0;
                    if (step_reg == '0) begin
                        // No progress possible: report the saturated time
                        secs_next  = psr_pkg::SECS_NO_STEP;
                        state_next = ST_EMIT;
                    end else begin
                        div_req.start = 1'b1;
                        state_next    = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    state_next = ST_SECS;
                end
            end
            ST_SECS: begin
                secs_next  = psr_pkg::SECS_W'(sec_prod >> psr_pkg::SEC_SHIFT);
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                // Hold here until the output register can take the result
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_kind_next   = kind_reg;
                    m_pos_next    = cur_pos_reg;
                    m_bright_next = psr_pkg::BRIGHT_W'(bri_prod >> psr_pkg::BRI_SHIFT);
                    m_secs_next   = secs_reg;
                    m_just_next   = just_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cur_pos_reg <= '0;
            tgt_pos_reg <= '0;
            step_reg    <= '0;
            moving_reg  <= 1'b0;
            first_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cur_pos_reg <= cur_pos_next;
            tgt_pos_reg <= tgt_pos_next;
            step_reg    <= step_next;
            moving_reg  <= moving_next;
            first_reg   <= first_next;
            m_valid_reg <= m_valid_next;
        end
        kind_reg     <= kind_next;
        secs_reg     <= secs_next;
        just_reg     <= just_next;
        m_kind_reg   <= m_kind_next;
        m_pos_reg    <= m_pos_next;
        m_bright_reg <= m_bright_next;
        m_secs_reg   <= m_secs_next;
        m_just_reg   <= m_just_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_event_kind   = m_kind_reg;
    assign m_position     = m_pos_reg;
    assign m_brightness   = m_bright_reg;
    assign m_time_left_s  = m_secs_reg;
    assign m_just_started = m_just_reg;

endmodule

[bench/tb_position_slew_ramp_core.sv]
module tb_position_slew_ramp_core;

    // Selector three: the block drops it without a result
    localparam logic [psr_pkg::FUNC_W-1:0] FUNC_IGNORED = 2'd3;

    localparam int N_RANDOM     = 680;     // random requests that the block acts on
    localparam int LIMIT        = 600000;  // watchdog, in clock cycles
    localparam int HOLD_CYCLES  = 300;     // long receiver hold-off
    localparam int HOLD_AT      = 120;     // issued requests before the hold-off starts
    localparam int DRAIN_CYCLES = 60;      // settle time after the last result

    // One request as offered on the input channel; drain holds it back until
    // every outstanding report has come out
    typedef struct {
        logic [psr_pkg::FUNC_W-1:0]  func;
        logic [psr_pkg::POS_W-1:0]   target;
        logic [psr_pkg::SPEED_W-1:0] speed;
        bit                          drain;
    } ramp_req_t;

    typedef struct packed {
        logic                         kind;
        logic [psr_pkg::POS_W-1:0]    pos;
        logic [psr_pkg::BRIGHT_W-1:0] bright;
        logic [psr_pkg::SECS_W-1:0]   secs;
        logic                         fresh;
    } ramp_report_t;

    logic                          aclk;
    logic                          aresetn           = 1'b0;
    logic                          s_valid           = 1'b0;
    logic                          s_ready;
    logic [psr_pkg::FUNC_W-1:0]    s_func            = psr_pkg::FUNC_TICK;
    logic [psr_pkg::POS_W-1:0]     s_target_position = '0;
    logic [psr_pkg::SPEED_W-1:0]   s_move_speed      = '0;
    logic                          m_valid;
    logic                          m_ready           = 1'b0;
    logic                          m_event_kind;
    logic [psr_pkg::POS_W-1:0]     m_position;
    logic [psr_pkg::BRIGHT_W-1:0]  m_brightness;
    logic [psr_pkg::SECS_W-1:0]    m_time_left_s;
    logic                          m_just_started;

    ramp_req_t    request_queue[$];
    ramp_report_t expected_reports[$];

    int n_items      = 0;
    int issued_cnt   = 0;
    int accepted_cnt = 0;
    int n_fail       = 0;
    int cycle_cnt    = 0;
    int hold_left    = 0;
    bit hold_done    = 1'b0;
    int phase;

    // Shadow copy of the ramp state
    logic [psr_pkg::POS_W-1:0]   ramp_pos    = '0;
    logic [psr_pkg::POS_W-1:0]   ramp_tgt    = '0;
    logic [psr_pkg::SPEED_W-1:0] ramp_speed  = '0;
    bit                          ramp_moving = 1'b0;
    bit                          ramp_fresh  = 1'b0;

    position_slew_ramp_core uut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_func            (s_func),
        .s_target_position (s_target_position),
        .s_move_speed      (s_move_speed),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_event_kind      (m_event_kind),
        .m_position        (m_position),
        .m_brightness      (m_brightness),
        .m_time_left_s     (m_time_left_s),
        .m_just_started    (m_just_started)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Indicator level: position*255/10000, rounded to nearest
    function automatic logic [psr_pkg::BRIGHT_W-1:0] pos_level(input int unsigned p);
        return psr_pkg::BRIGHT_W'((p * 255 + 5000) / 10000);
    endfunction

    function automatic ramp_report_t stopped_at(input logic [psr_pkg::POS_W-1:0] p);
        ramp_report_t rep;
        rep.kind   = psr_pkg::EVT_STOPPED;
        rep.pos    = p;
        rep.bright = pos_level(p);
        rep.secs   = '0;
        rep.fresh  = 1'b0;
        return rep;
    endfunction

    // Apply one accepted request to the shadow state; return 1 and fill rep
    // when the request yields a report
    function automatic bit ramp_response(input ramp_req_t r, output ramp_report_t rep);
        int unsigned step;
        int unsigned dist_abs;
        int unsigned secs;
        bit          rising;
        rep = '0;
        case (r.func)
            psr_pkg::FUNC_START: begin
                // Saturate out-of-range targets, arm the just-started flag
                ramp_tgt    = (r.target > psr_pkg::POS_MAX) ? psr_pkg::POS_MAX : r.target;
                ramp_speed  = r.speed;
                ramp_moving = 1'b1;
                ramp_fresh  = 1'b1;
                return 1'b0;
            end
            psr_pkg::FUNC_STOP: begin
                // Report even when already idle
                ramp_moving = 1'b0;
                rep = stopped_at(ramp_pos);
                return 1'b1;
            end
            psr_pkg::FUNC_TICK: begin
                if (!ramp_moving)
                    return 1'b0;
                step     = (int'(ramp_speed) * 100) / 1000;
                rising   = ramp_pos <= ramp_tgt;
                dist_abs = rising ? ramp_tgt - ramp_pos : ramp_pos - ramp_tgt;
                if (step >= dist_abs) begin
                    // Snap to the target and stop
                    ramp_pos    = ramp_tgt;
                    ramp_moving = 1'b0;
                    rep = stopped_at(ramp_pos);
                    return 1'b1;
                end
                ramp_pos = rising ? psr_pkg::POS_W'(ramp_pos + step)
                                  : psr_pkg::POS_W'(ramp_pos - step);
                // Time left uses the distance before this step; a zero step
                // holds position and reports the all-ones time
                if (step == 0)
                    secs = 65535;
                else
                    secs = ((dist_abs * 100) / step + 999) / 1000;
                if (secs > 65535)
                    secs = 65535;
                rep.kind   = psr_pkg::EVT_UPDATE;
                rep.pos    = ramp_pos;
                rep.bright = pos_level(ramp_pos);
                rep.secs   = psr_pkg::SECS_W'(secs);
                rep.fresh  = ramp_fresh;
                ramp_fresh = 1'b0;
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    task automatic queue_request(input logic [psr_pkg::FUNC_W-1:0] func,
                                 input int unsigned target,
                                 input int unsigned speed, input bit drain);
        ramp_req_t r;
        r.func   = func;
        r.target = psr_pkg::POS_W'(target);
        r.speed  = psr_pkg::SPEED_W'(speed);
        r.drain  = drain;
        request_queue.push_back(r);
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d got %0d", $time, name, want, got);
            n_fail++;
        end
    endtask

    // Pick the random target: mostly in range, some at the ends, some above
    // range to exercise saturation and the top bits
    function automatic int unsigned pick_target();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 10)
            return $urandom_range(0, 16383);
        if (sel < 20)
            return $urandom_range(0, 1) ? 10000 : 0;
        return $urandom_range(0, 10000);
    endfunction

    // Pick the random speed: mostly fast enough to arrive within a few ticks,
    // some slow, some with a zero step
    function automatic int unsigned pick_speed();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 8)
            return $urandom_range(0, 9);
        if (sel < 30)
            return $urandom_range(10, 999);
        return $urandom_range(1000, 65535);
    endfunction

    // Sender and receiver idle rates change by thirds of the run
    always @* begin
        if (issued_cnt * 3 < n_items)
            phase = 0;
        else if (issued_cnt * 3 < 2 * n_items)
            phase = 1;
        else
            phase = 2;
    end

    // Stimulus: build the request list, then release reset and wait for the end
    initial begin
        int unsigned counted;
        int unsigned n_ticks;
        int unsigned sel;
        int          k;

        // Directed part
        queue_request(psr_pkg::FUNC_TICK, 0, 0, 0);              // tick while idle
        queue_request(psr_pkg::FUNC_STOP, 0, 0, 0);              // stop while idle
        queue_request(FUNC_IGNORED, 16383, 65535, 0);           // selector three
        queue_request(psr_pkg::FUNC_START, 16383, 65535, 0);     // saturating target
        queue_request(psr_pkg::FUNC_TICK, 16383, 65535, 0);      // first update
        queue_request(psr_pkg::FUNC_TICK, 0, 0, 0);              // arrive at the top
        queue_request(psr_pkg::FUNC_TICK, 0, 0, 0);              // idle again
        queue_request(psr_pkg::FUNC_START, 10000, 0, 0);         // already at target
        queue_request(psr_pkg::FUNC_TICK, 0, 0, 0);              // arrives at once
        queue_request(psr_pkg::FUNC_START, 0, 0, 0);             // zero step, away
        queue_request(psr_pkg::FUNC_TICK, 0, 0, 0);
        queue_request(psr_pkg::FUNC_TICK, 0, 0, 0);
        queue_request(psr_pkg::FUNC_STOP, 0, 0, 0);              // stop mid-motion
        queue_request(psr_pkg::FUNC_START, 0, 9, 0);             // speed below one step
        queue_request(psr_pkg::FUNC_TICK, 0, 0, 0);
        queue_request(psr_pkg::FUNC_START, 5000, 10, 0);         // unit step, long time
        queue_request(psr_pkg::FUNC_TICK, 0, 0, 0);
        queue_request(psr_pkg::FUNC_START, 1, 65535, 0);         // move down
        queue_request(psr_pkg::FUNC_TICK, 0, 0, 0);
        queue_request(psr_pkg::FUNC_TICK, 0, 0, 0);
        queue_request(psr_pkg::FUNC_START, 0, 10, 0);            // exactly one step left
        queue_request(psr_pkg::FUNC_TICK, 0, 0, 0);
        queue_request(psr_pkg::FUNC_START, 10000, 19999, 0);
        queue_request(psr_pkg::FUNC_TICK, 0, 0, 0);

        // Random part: mostly start followed by a run of ticks, the rest noise
        counted = 0;
        while (counted < N_RANDOM) begin
            sel = $urandom_range(0, 99);
            if (sel < 88) begin
                queue_request(psr_pkg::FUNC_START, pick_target(), pick_speed(),
                              counted == 0 || $urandom_range(0, 39) == 0);
                counted++;
                n_ticks = $urandom_range(1, 14);
                for (k = 0; k < n_ticks; k++) begin
                    sel = $urandom_range(0, 99);
                    if (sel < 6) begin
                        queue_request(psr_pkg::FUNC_STOP, $urandom_range(0, 16383),
                                      $urandom_range(0, 65535), 0);
                        counted++;
                    end else if (sel < 9) begin
                        queue_request(FUNC_IGNORED, $urandom_range(0, 16383),
                                      $urandom_range(0, 65535), 0);
                    end
                    // Tick payload fields are don't-care; vary them anyway
                    queue_request(psr_pkg::FUNC_TICK, $urandom_range(0, 16383),
                                  $urandom_range(0, 65535), 0);
                    counted++;
                end
            end else if (sel < 94) begin
                queue_request(psr_pkg::FUNC_STOP, $urandom_range(0, 16383),
                              $urandom_range(0, 65535), 0);
                counted++;
            end else if (sel < 97) begin
                queue_request(psr_pkg::FUNC_TICK, $urandom_range(0, 16383),
                              $urandom_range(0, 65535), 0);
                counted++;
            end else begin
                queue_request(FUNC_IGNORED, $urandom_range(0, 16383),
                              $urandom_range(0, 65535), 0);
            end
        end
        n_items = request_queue.size();

        // Hold reset, then release it on a falling edge
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (accepted_cnt != n_items)
            @(negedge aclk);
        while (expected_reports.size() != 0)
            @(negedge aclk);
        // Let any late or spurious result show up
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (n_fail == 0)
            $display("** position_slew_ramp_core: PASSED **");
        else
            $display("** position_slew_ramp_core: FAILED **");
        $finish;
    end

    // Driver: advance to the next request once the current one is taken
    always @(negedge aclk) begin : driver
        ramp_req_t   nx;
        int unsigned idle_pct;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || accepted_cnt == issued_cnt) begin
            idle_pct = (phase == 0) ? 14 : (phase == 1) ? 87 : 0;
            if (request_queue.size() == 0
                    || (request_queue[0].drain && expected_reports.size() != 0)
                    || $urandom_range(0, 99) < idle_pct) begin
                s_valid <= 1'b0;
            end else begin
                nx = request_queue.pop_front();
                s_valid           <= 1'b1;
                s_func            <= nx.func;
                s_target_position <= nx.target;
                s_move_speed      <= nx.speed;
                issued_cnt        <= issued_cnt + 1;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off so the block backs up
    // and drops s_ready while the sender keeps offering
    always @(negedge aclk) begin : receiver
        int unsigned stall_pct;
        stall_pct = (phase == 0) ? 87 : (phase == 1) ? 14 : 0;
        if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && aresetn && issued_cnt >= HOLD_AT) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= $urandom_range(0, 99) >= stall_pct;
        end
    end

    // Monitor: check the result first, then predict from the accepted request,
    // so a report leaving in the same cycle is matched against older requests
    always @(posedge aclk) begin : monitor
        ramp_report_t want;
        ramp_req_t    r;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_reports.size() == 0) begin
                    $display("%0t: unexpected result, expected none got kind %0d pos %0d",
                             $time, m_event_kind, m_position);
                    n_fail++;
                end else begin
                    want = expected_reports.pop_front();
                    check_field("event_kind", want.kind, m_event_kind);
                    check_field("position", want.pos, m_position);
                    check_field("brightness", want.bright, m_brightness);
                    check_field("time_left_s", want.secs, m_time_left_s);
                    check_field("just_started", want.fresh, m_just_started);
                end
            end
            if (s_valid && s_ready) begin
                r.func   = s_func;
                r.target = s_target_position;
                r.speed  = s_move_speed;
                r.drain  = 1'b0;
                if (ramp_response(r, want))
                    expected_reports.push_back(want);
                accepted_cnt <= accepted_cnt + 1;
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT) begin
            $display("** position_slew_ramp_core: FAILED **");
            $finish;
        end
    end

endmodule
